[hdl/yuv2rgb_pkg.sv]
// Shared types, coefficients and the byte clamp for the pixel-pair YUV to RGB converter.
// No dependencies; every other file in hdl/ imports this package.
package yuv2rgb_pkg;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] luma_second;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } yuv2rgb_req_type;

   typedef struct packed {
      logic [7:0] left_slot_zero;
      logic [7:0] left_slot_one;
      logic [7:0] left_slot_two;
      logic [7:0] right_slot_zero;
      logic [7:0] right_slot_one;
      logic [7:0] right_slot_two;
   } yuv2rgb_rsp_type;

   typedef struct packed {
      logic [7:0] slot_zero;
      logic [7:0] slot_one;
      logic [7:0] slot_two;
   } yuv2rgb_pixel_type;

   // source_format codes
   localparam logic FORMAT_YUY2 = 1'b0;
   localparam logic FORMAT_NV12 = 1'b1;

   // Chroma and offset luma, signed, -128..239
   typedef logic signed [8:0] chroma_type;
   localparam chroma_type CHROMA_OFFSET = 9'sd128;
   localparam chroma_type LUMA_OFFSET   = 9'sd16;
   localparam logic [7:0] CHROMA_NEUTRAL = 8'd128;

   // Studio path: 20-bit signed accumulators, result taken from bits above the shift
   localparam int STUDIO_W    = 20;
   localparam int STUDIO_SHIFT = 8;
   typedef logic signed [STUDIO_W-1:0] studio_sum_type;
   localparam studio_sum_type COEF_Y       = 20'sd298;
   localparam studio_sum_type COEF_RV      = 20'sd409;
   localparam studio_sum_type COEF_GU      = 20'sd100;
   localparam studio_sum_type COEF_GV      = 20'sd208;
   localparam studio_sum_type COEF_BU      = 20'sd516;
   localparam studio_sum_type STUDIO_ROUND = 20'sd128;

   // Value ahead of the clamp, wide enough for both paths
   localparam int WIDE_W = STUDIO_W - STUDIO_SHIFT;
   typedef logic signed [WIDE_W-1:0] wide_pixel_type;

   // Percent path: chroma product, its magnitude, divide by 100 via reciprocal
   typedef logic signed [15:0] pct_prod_type;
   typedef logic [14:0]        pct_mag_type;
   typedef logic [27:0]        recip_prod_type;
   typedef logic [8:0]         pct_quot_type;
   typedef logic signed [9:0]  pct_squot_type;
   localparam int PCT_TERMS = 4;
   localparam int TERM_RED     = 0;
   localparam int TERM_GREEN_U = 1;
   localparam int TERM_GREEN_V = 2;
   localparam int TERM_BLUE    = 3;
   localparam pct_prod_type PCT_COEF [PCT_TERMS] = '{16'sd140, 16'sd34, 16'sd71, 16'sd177};
   // floor(m * 5243 / 2^19) == floor(m / 100) for all m below 2^15 used here
   localparam recip_prod_type RECIP_100   = 28'd5243;
   localparam int             RECIP_SHIFT = 19;

   function automatic logic [7:0] clamp_byte(input wide_pixel_type value);
      logic [7:0] result;
      if (value < 0) begin
         result = 8'd0;
      end else if (value > wide_pixel_type'(255)) begin
         result = 8'd255;
      end else begin
         result = value[7:0];
      end
      return result;
   endfunction

endpackage

[hdl/yuv2rgb_studio.sv]
// Three-stage BT.601 studio-range conversion of one pixel: R, G, B in slots zero..two.
// Depends on yuv2rgb_pkg.
module yuv2rgb_studio (
   input  logic                          clock,
   input  logic [7:0]                    luma,
   input  yuv2rgb_pkg::chroma_type       chroma_blue_off,
   input  yuv2rgb_pkg::chroma_type       chroma_red_off,
   output yuv2rgb_pkg::yuv2rgb_pixel_type pixel
);
   import yuv2rgb_pkg::*;

   chroma_type        luma_off;
   studio_sum_type    y_term_in, red_term_in, green_term_in, blue_term_in;
   studio_sum_type    y_term_ff, red_term_ff, green_term_ff, blue_term_ff;
   studio_sum_type    red_sum_in, green_sum_in, blue_sum_in;
   studio_sum_type    red_sum_ff, green_sum_ff, blue_sum_ff;
   yuv2rgb_pixel_type pixel_in, pixel_ff;

   always_comb begin
      luma_off      = $signed({1'b0, luma}) - LUMA_OFFSET;
      y_term_in     = studio_sum_type'(luma_off) * COEF_Y;
      red_term_in   = studio_sum_type'(chroma_red_off) * COEF_RV;
      green_term_in = -(studio_sum_type'(chroma_blue_off) * COEF_GU)
                      - (studio_sum_type'(chroma_red_off) * COEF_GV);
      blue_term_in  = studio_sum_type'(chroma_blue_off) * COEF_BU;

      red_sum_in   = y_term_ff + red_term_ff + STUDIO_ROUND;
      green_sum_in = y_term_ff + green_term_ff + STUDIO_ROUND;
      blue_sum_in  = y_term_ff + blue_term_ff + STUDIO_ROUND;

      // floor shift by 8: keep the upper bits as signed
      pixel_in.slot_zero = clamp_byte($signed(red_sum_ff[STUDIO_W-1:STUDIO_SHIFT]));
      pixel_in.slot_one  = clamp_byte($signed(green_sum_ff[STUDIO_W-1:STUDIO_SHIFT]));
      pixel_in.slot_two  = clamp_byte($signed(blue_sum_ff[STUDIO_W-1:STUDIO_SHIFT]));
   end

   always_ff @(posedge clock) begin
      y_term_ff     <= y_term_in;
      red_term_ff   <= red_term_in;
      green_term_ff <= green_term_in;
      blue_term_ff  <= blue_term_in;
      red_sum_ff    <= red_sum_in;
      green_sum_ff  <= green_sum_in;
      blue_sum_ff   <= blue_sum_in;
      pixel_ff      <= pixel_in;
   end

   assign pixel = pixel_ff;

endmodule

[hdl/yuv2rgb_percent.sv]
// Three-stage percent-coefficient conversion of a pixel pair: B, G, R in slots zero..two.
// Chroma terms are shared by both pixels. Depends on yuv2rgb_pkg.
module yuv2rgb_percent (
   input  logic                           clock,
   input  logic [7:0]                     luma_first,
   input  logic [7:0]                     luma_second,
   input  yuv2rgb_pkg::chroma_type        chroma_blue_off,
   input  yuv2rgb_pkg::chroma_type        chroma_red_off,
   output yuv2rgb_pkg::yuv2rgb_pixel_type pixel_left,
   output yuv2rgb_pkg::yuv2rgb_pixel_type pixel_right
);
   import yuv2rgb_pkg::*;

   chroma_type        term_chroma [PCT_TERMS];
   pct_prod_type      term_prod   [PCT_TERMS];
   pct_mag_type       mag_in      [PCT_TERMS];
   pct_mag_type       mag_ff      [PCT_TERMS];
   logic              neg_in      [PCT_TERMS];
   logic              neg_ff      [PCT_TERMS];
   recip_prod_type    recip_prod  [PCT_TERMS];
   pct_quot_type      quot        [PCT_TERMS];
   pct_squot_type     squot_in    [PCT_TERMS];
   pct_squot_type     squot_ff    [PCT_TERMS];
   logic [7:0]        luma_s1_ff  [2];
   logic [7:0]        luma_s2_ff  [2];
   wide_pixel_type    luma_wide   [2];
   wide_pixel_type    red_wide, green_chroma, blue_wide;
   yuv2rgb_pixel_type pixel_in    [2];
   yuv2rgb_pixel_type pixel_ff    [2];

   always_comb begin
      term_chroma[TERM_RED]     = chroma_red_off;
      term_chroma[TERM_GREEN_U] = chroma_blue_off;
      term_chroma[TERM_GREEN_V] = chroma_red_off;
      term_chroma[TERM_BLUE]    = chroma_blue_off;

      // truncate toward zero: divide the magnitude, restore the sign
      for (int t = 0; t < PCT_TERMS; t++) begin
         term_prod[t]  = pct_prod_type'(term_chroma[t]) * PCT_COEF[t];
         neg_in[t]     = term_prod[t][15];
         mag_in[t]     = neg_in[t] ? pct_mag_type'(-term_prod[t]) : term_prod[t][14:0];
         recip_prod[t] = recip_prod_type'(mag_ff[t]) * RECIP_100;
         quot[t]       = recip_prod[t][RECIP_SHIFT+8:RECIP_SHIFT];
         squot_in[t]   = neg_ff[t] ? -$signed({1'b0, quot[t]}) : $signed({1'b0, quot[t]});
      end

      red_wide     = wide_pixel_type'(squot_ff[TERM_RED]);
      green_chroma = wide_pixel_type'(squot_ff[TERM_GREEN_U])
                     + wide_pixel_type'(squot_ff[TERM_GREEN_V]);
      blue_wide    = wide_pixel_type'(squot_ff[TERM_BLUE]);

      for (int p = 0; p < 2; p++) begin
         luma_wide[p]          = wide_pixel_type'($signed({1'b0, luma_s2_ff[p]}));
         pixel_in[p].slot_zero = clamp_byte(luma_wide[p] + blue_wide);
         pixel_in[p].slot_one  = clamp_byte(luma_wide[p] - green_chroma);
         pixel_in[p].slot_two  = clamp_byte(luma_wide[p] + red_wide);
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < PCT_TERMS; t++) begin
         mag_ff[t]   <= mag_in[t];
         neg_ff[t]   <= neg_in[t];
         squot_ff[t] <= squot_in[t];
      end
      luma_s1_ff[0] <= luma_first;
      luma_s1_ff[1] <= luma_second;
      for (int p = 0; p < 2; p++) begin
         luma_s2_ff[p] <= luma_s1_ff[p];
         pixel_ff[p]   <= pixel_in[p];
      end
   end

   assign pixel_left  = pixel_ff[0];
   assign pixel_right = pixel_ff[1];

endmodule

[hdl/yuv_pixel_pair_to_rgb.sv]
// Top level of the pixel-pair YUV to RGB converter: input register, valid/format
// pipeline, format select and output register. Depends on yuv2rgb_pkg,
// yuv2rgb_studio and yuv2rgb_percent.
//
// Usage:
//   Input: drive req_payload (two luma samples and their shared chroma pair) and
//   raise start; the item is taken at any rising edge with start high and busy low.
//   busy stays low, so one item can be taken in every cycle.
//   Output: rsp_valid is high for exactly one cycle per item, with both converted
//   pixels on rsp_payload; the receiver must take it then, it cannot stall.
//   Path: an item taken passes through the input register, three arithmetic
//   stages and the output register before it is shown on rsp_payload.
//   Throughput: one item per cycle, set by the five-stage pipeline.
//   Configuration: csr_write_enable writes csr_write_data into the source format
//   (YUY2 studio formula or NV12 percent formula with blue/red swap). Write it
//   only with no item in flight; each item carries the format it was taken with.
//   Reset: synchronous, clears the format to YUY2 and drops all items in flight.
module yuv_pixel_pair_to_rgb (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  yuv2rgb_pkg::yuv2rgb_req_type req_payload,
   input  logic                         csr_write_enable,
   input  logic                         csr_write_data,
   output logic                         rsp_valid,
   output yuv2rgb_pkg::yuv2rgb_rsp_type rsp_payload
);
   import yuv2rgb_pkg::*;

   localparam int DEPTH = 4;

   logic              accept;
   logic              format_ff;
   yuv2rgb_req_type   req_ff;
   logic [DEPTH-1:0]  valid_pipe_ff, valid_pipe_in;
   logic [DEPTH-1:0]  fmt_pipe_ff, fmt_pipe_in;
   chroma_type        chroma_blue_off, chroma_red_off;
   yuv2rgb_pixel_type studio_left, studio_right, pct_left, pct_right;
   yuv2rgb_rsp_type   rsp_in, rsp_ff;
   logic              rsp_valid_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      chroma_blue_off = $signed({1'b0, req_ff.chroma_blue}) - CHROMA_OFFSET;
      chroma_red_off  = $signed({1'b0, req_ff.chroma_red}) - CHROMA_OFFSET;

      valid_pipe_in = {valid_pipe_ff[DEPTH-2:0], accept};
      fmt_pipe_in   = {fmt_pipe_ff[DEPTH-2:0], format_ff};

      if (fmt_pipe_ff[DEPTH-1] == FORMAT_NV12) begin
         rsp_in.left_slot_zero  = pct_left.slot_zero;
         rsp_in.left_slot_one   = pct_left.slot_one;
         rsp_in.left_slot_two   = pct_left.slot_two;
         rsp_in.right_slot_zero = pct_right.slot_zero;
         rsp_in.right_slot_one  = pct_right.slot_one;
         rsp_in.right_slot_two  = pct_right.slot_two;
      end else begin
         rsp_in.left_slot_zero  = studio_left.slot_zero;
         rsp_in.left_slot_one   = studio_left.slot_one;
         rsp_in.left_slot_two   = studio_left.slot_two;
         rsp_in.right_slot_zero = studio_right.slot_zero;
         rsp_in.right_slot_one  = studio_right.slot_one;
         rsp_in.right_slot_two  = studio_right.slot_two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff     <= FORMAT_YUY2;
         valid_pipe_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            format_ff <= csr_write_data;
         end
         valid_pipe_ff <= valid_pipe_in;
         rsp_valid_ff  <= valid_pipe_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_payload;
      fmt_pipe_ff <= fmt_pipe_in;
      rsp_ff      <= rsp_in;
   end

   yuv2rgb_studio u_studio_left (
      .clock           (clock),
      .luma            (req_ff.luma_first),
      .chroma_blue_off (chroma_blue_off),
      .chroma_red_off  (chroma_red_off),
      .pixel           (studio_left)
   );

   yuv2rgb_studio u_studio_right (
      .clock           (clock),
      .luma            (req_ff.luma_second),
      .chroma_blue_off (chroma_blue_off),
      .chroma_red_off  (chroma_red_off),
      .pixel           (studio_right)
   );

   yuv2rgb_percent u_percent (
      .clock           (clock),
      .luma_first      (req_ff.luma_first),
      .luma_second     (req_ff.luma_second),
      .chroma_blue_off (chroma_blue_off),
      .chroma_red_off  (chroma_red_off),
      .pixel_left      (pct_left),
      .pixel_right     (pct_right)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   // every taken item comes out at the output with rsp_valid high
   a_item_emerges: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("taken item did not reach the output on time");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result without a taken item");

   // equal luma in a pair must give equal pixels in either format
   a_pair_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_payload.luma_first == req_payload.luma_second, 5)
      |-> rsp_payload.left_slot_zero == rsp_payload.right_slot_zero
          && rsp_payload.left_slot_one == rsp_payload.right_slot_one
          && rsp_payload.left_slot_two == rsp_payload.right_slot_two)
      else $error("left and right pixels differ for equal luma");

   // NV12 with neutral chroma passes luma straight to all three slots
   a_neutral_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(format_ff == FORMAT_NV12
                         && req_payload.chroma_blue == CHROMA_NEUTRAL
                         && req_payload.chroma_red == CHROMA_NEUTRAL, 5)
      |-> rsp_payload.left_slot_zero == rsp_payload.left_slot_one
          && rsp_payload.left_slot_one == rsp_payload.left_slot_two
          && rsp_payload.left_slot_zero == $past(req_payload.luma_first, 5))
      else $error("neutral chroma did not give gray in NV12 mode");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for yuv_pixel_pair_to_rgb: drives pixel-pair items in bursts,
// predicts both pixels for YUY2 and NV12 formats and compares every result.
// Depends on yuv2rgb_pkg and the RTL under hdl/.

module tb_top;
   import yuv2rgb_pkg::*;

   class pixel_pair_scoreboard;
      yuv2rgb_rsp_type expected_q[$];
      logic            format;
      int unsigned     mismatches;
      int unsigned     checked;
      int unsigned     yuy2_items;
      int unsigned     nv12_items;

      function new();
         format     = FORMAT_YUY2;
         mismatches = 0;
         checked    = 0;
         yuy2_items = 0;
         nv12_items = 0;
      endfunction

      function logic [7:0] saturate(int value);
         if (value < 0) return 8'd0;
         if (value > 255) return 8'd255;
         return value[7:0];
      endfunction

      function yuv2rgb_pixel_type studio_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
         yuv2rgb_pixel_type px;
         int c, d, e;
         c = int'(y) - 16;
         d = int'(u) - 128;
         e = int'(v) - 128;
         // arithmetic shift of a signed int floors toward minus infinity
         px.slot_zero = saturate((298 * c + 409 * e + 128) >>> 8);
         px.slot_one  = saturate((298 * c - 100 * d - 208 * e + 128) >>> 8);
         px.slot_two  = saturate((298 * c + 516 * d + 128) >>> 8);
         return px;
      endfunction

      function yuv2rgb_pixel_type percent_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
         yuv2rgb_pixel_type px;
         int d, e;
         d = int'(u) - 128;
         e = int'(v) - 128;
         // integer division truncates toward zero; blue goes to slot zero here
         px.slot_zero = saturate(int'(y) + (177 * d) / 100);
         px.slot_one  = saturate(int'(y) - (34 * d) / 100 - (71 * e) / 100);
         px.slot_two  = saturate(int'(y) + (140 * e) / 100);
         return px;
      endfunction

      function yuv2rgb_rsp_type convert_pair(yuv2rgb_req_type item, logic fmt);
         yuv2rgb_pixel_type left_px, right_px;
         yuv2rgb_rsp_type   pair;
         if (fmt == FORMAT_NV12) begin
            left_px  = percent_pixel(item.luma_first, item.chroma_blue, item.chroma_red);
            right_px = percent_pixel(item.luma_second, item.chroma_blue, item.chroma_red);
         end else begin
            left_px  = studio_pixel(item.luma_first, item.chroma_blue, item.chroma_red);
            right_px = studio_pixel(item.luma_second, item.chroma_blue, item.chroma_red);
         end
         pair.left_slot_zero  = left_px.slot_zero;
         pair.left_slot_one   = left_px.slot_one;
         pair.left_slot_two   = left_px.slot_two;
         pair.right_slot_zero = right_px.slot_zero;
         pair.right_slot_one  = right_px.slot_one;
         pair.right_slot_two  = right_px.slot_two;
         return pair;
      endfunction

      function void note_pair(yuv2rgb_req_type item);
         expected_q = {expected_q, convert_pair(item, format)};
         if (format == FORMAT_NV12) nv12_items++;
         else yuy2_items++;
      endfunction

      function void compare_byte(string field, logic [7:0] exp_val, logic [7:0] act_val);
         if (act_val !== exp_val) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
         end
      endfunction

      function void check_pixels(yuv2rgb_rsp_type got);
         yuv2rgb_rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, expected nothing actual %h", $time, got);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_byte("left_slot_zero", want.left_slot_zero, got.left_slot_zero);
         compare_byte("left_slot_one", want.left_slot_one, got.left_slot_one);
         compare_byte("left_slot_two", want.left_slot_two, got.left_slot_two);
         compare_byte("right_slot_zero", want.right_slot_zero, got.right_slot_zero);
         compare_byte("right_slot_one", want.right_slot_one, got.right_slot_one);
         compare_byte("right_slot_two", want.right_slot_two, got.right_slot_two);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   yuv2rgb_req_type req_payload;
   logic            csr_write_enable;
   logic            csr_write_data;
   logic            rsp_valid;
   yuv2rgb_rsp_type rsp_payload;

   pixel_pair_scoreboard pair_sb;
   int unsigned          cycle_count;

   yuv_pixel_pair_to_rgb u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = FORMAT_YUY2;
      pair_sb          = new();
      cycle_count      = 0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Note accepted items with the format in force, then apply any format write.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) pair_sb.note_pair(req_payload);
         if (rsp_valid) pair_sb.check_pixels(rsp_payload);
         if (csr_write_enable) pair_sb.format = csr_write_data;
      end
   end

   task automatic send_pair(input yuv2rgb_req_type item);
      @(negedge clock);
      start       = 1'b1;
      req_payload = item;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic wait_drained();
      hold_off(1);
      while (pair_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_format(input logic fmt);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = fmt;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic yuv2rgb_req_type make_pair(logic [7:0] y0, logic [7:0] y1,
                                                 logic [7:0] u, logic [7:0] v);
      yuv2rgb_req_type item;
      item.luma_first  = y0;
      item.luma_second = y1;
      item.chroma_blue = u;
      item.chroma_red  = v;
      return item;
   endfunction

   function automatic logic [7:0] edge_value();
      logic [7:0] picks [8] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd235, 8'd240, 8'd254, 8'd255};
      return picks[$urandom_range(0, 7)];
   endfunction

   function automatic yuv2rgb_req_type random_pair();
      case ($urandom_range(0, 3))
         0: begin
            // near-neutral chroma keeps most channels out of saturation
            return make_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(108, 148)), 8'($urandom_range(108, 148)));
         end
         1: begin
            return make_pair(edge_value(), edge_value(), edge_value(), edge_value());
         end
         default: begin
            return make_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   task automatic directed_pairs();
      send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0));
      send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255));
      send_pair(make_pair(8'd0, 8'd255, 8'd0, 8'd255));
      send_pair(make_pair(8'd255, 8'd0, 8'd255, 8'd0));
      send_pair(make_pair(8'd16, 8'd235, CHROMA_NEUTRAL, CHROMA_NEUTRAL));
      send_pair(make_pair(8'd128, 8'd128, CHROMA_NEUTRAL, CHROMA_NEUTRAL));
      send_pair(make_pair(8'd15, 8'd17, 8'd127, 8'd129));
      send_pair(make_pair(8'd81, 8'd145, 8'd90, 8'd240));
      send_pair(make_pair(8'd41, 8'd210, 8'd240, 8'd110));
      send_pair(make_pair(8'd170, 8'd106, 8'd166, 8'd16));
      send_pair(make_pair(8'd200, 8'd50, 8'd1, 8'd254));
      send_pair(make_pair(8'h55, 8'hAA, 8'hAA, 8'h55));
   endtask

   task automatic random_phase(input int unsigned count, input bit mid_drain);
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int unsigned k = 0; k < burst && sent < count; k++) begin
            send_pair(random_pair());
            sent++;
            if (mid_drain && sent == count / 2) wait_drained();
         end
         // some bursts run straight into the next one
         if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 7));
      end
   endtask

   initial begin
      logic phase_formats [6];
      phase_formats = '{FORMAT_YUY2, FORMAT_NV12, FORMAT_NV12,
                        FORMAT_YUY2, FORMAT_NV12, FORMAT_YUY2};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset value selects YUY2 with no write
      directed_pairs();
      wait_drained();
      write_format(FORMAT_NV12);
      directed_pairs();
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_format(phase_formats[p]);
         random_phase(100, p == 2);
         wait_drained();
      end

      $display("Covered %0d YUY2 and %0d NV12 pixel pairs over 8 format phases,",
               pair_sb.yuy2_items, pair_sb.nv12_items);
      $display("%0d results compared, %0d still outstanding", pair_sb.checked,
               pair_sb.pending());
      if (pair_sb.mismatches == 0 && pair_sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
